FILE: rtl/qap_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qap_pkg;

  typedef struct packed {
    logic signed [31:0] theta_x;
    logic signed [31:0] theta_y;
    logic signed [31:0] theta_z;
  } in_t;

  typedef struct packed {
    logic [30:0]        att_w;
    logic signed [31:0] att_x;
    logic signed [31:0] att_y;
    logic signed [31:0] att_z;
    logic               norm_reset;
  } out_t;

  localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
  localparam logic [31:0]        SMALL_ANGLE = 32'd268;
  localparam logic [63:0]        NORM_EPS    = 64'd288230;
  localparam logic [31:0]        SAT_Q30     = 32'd1073741824;
  localparam logic [33:0]        CLAMP32     = 34'd2147483647;

  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [35:0] CORDIC_K    = 36'sd652032874;
  localparam int unsigned        CORDIC_ITERS = 30;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:    v = 30'd843314857;
      5'd1:    v = 30'd497837829;
      5'd2:    v = 30'd263043837;
      5'd3:    v = 30'd133525159;
      5'd4:    v = 30'd67021687;
      5'd5:    v = 30'd33543516;
      5'd6:    v = 30'd16775851;
      5'd7:    v = 30'd8388437;
      5'd8:    v = 30'd4194283;
      5'd9:    v = 30'd2097149;
      5'd10:   v = 30'd1048576;
      5'd11:   v = 30'd524288;
      5'd12:   v = 30'd262144;
      5'd13:   v = 30'd131072;
      5'd14:   v = 30'd65536;
      5'd15:   v = 30'd32768;
      5'd16:   v = 30'd16384;
      5'd17:   v = 30'd8192;
      5'd18:   v = 30'd4096;
      5'd19:   v = 30'd2048;
      5'd20:   v = 30'd1024;
      5'd21:   v = 30'd512;
      5'd22:   v = 30'd256;
      5'd23:   v = 30'd128;
      5'd24:   v = 30'd64;
      5'd25:   v = 30'd32;
      5'd26:   v = 30'd16;
      5'd27:   v = 30'd8;
      5'd28:   v = 30'd4;
      5'd29:   v = 30'd2;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // Hamilton product: term (k, j) uses b[k ^ j]; these terms are subtracted
  function automatic logic ham_neg(input logic [1:0] k, input logic [1:0] j);
    logic n;
    n = ((k == 2'd0) && (j != 2'd0)) ||
        ((k == 2'd1) && (j == 2'd3)) ||
        ((k == 2'd2) && (j == 2'd1)) ||
        ((k == 2'd3) && (j == 2'd2));
    return n;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] m;
    m = v[31] ? 32'(-v) : 32'(v);
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/quaternion_attitude_propagator_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Attitude propagator: holds a unit quaternion (identity after reset) and for each
// rotation increment (Q4.28 rad) forms exp(theta/2), normalises it, multiplies it
// onto the stored attitude from the left, normalises again and returns the new
// attitude in Q2.30 with a non-negative scalar part, plus a flag when a degenerate
// norm forced identity. One item is worked at a time through a shared bit-serial
// multiplier, a restoring divider, a digit-by-digit square root and a 30-step
// CORDIC; the up to thirty products and eleven divisions dominate, and an item
// takes less work below the small-angle threshold, where the CORDIC and the vector
// divisions are skipped. The input is stalled while an item is in work and while
// its result waits to enter the output register; a result held in that register
// does not hold up the next transfer on the input.

module quaternion_attitude_propagator_top import qap_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TSQ  = 4'd1;
  localparam logic [3:0] S_ASQ  = 4'd2;
  localparam logic [3:0] S_SIN  = 4'd3;
  localparam logic [3:0] S_VEC  = 4'd4;
  localparam logic [3:0] S_VDIV = 4'd5;
  localparam logic [3:0] S_NSQ  = 4'd6;
  localparam logic [3:0] S_NRT  = 4'd7;
  localparam logic [3:0] S_NDIV = 4'd8;
  localparam logic [3:0] S_NFIX = 4'd9;
  localparam logic [3:0] S_HAM  = 4'd10;
  localparam logic [3:0] S_HRND = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  logic [3:0]         state_q;
  logic               wait_q;
  logic               pass_q;
  logic               flag_q;
  logic [1:0]         idx_q;
  logic [1:0]         k_q;
  logic signed [31:0] theta_q [3];
  logic signed [31:0] att_q   [4];
  logic signed [31:0] dq_q    [4];
  logic signed [31:0] qw_q    [4];
  logic [63:0]        sum_q;
  logic [31:0]        a_q;
  logic [31:0]        r_q;
  logic signed [31:0] s_q;
  logic signed [63:0] acc_q;
  logic               out_valid_q;
  out_t               out_data_q;

  logic               mul_start, div_start, sqrt_start, cor_start;
  logic               mul_done, div_done, sqrt_done, cor_done;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic [63:0]        div_n;
  logic [31:0]        div_d;
  logic [63:0]        div_q;
  logic [31:0]        sqrt_root;
  logic signed [31:0] cor_sin, cor_cos;
  logic signed [35:0] cor_ang;
  logic               op_done;
  logic               issue;

  logic signed [31:0] th_sel;
  logic signed [31:0] qw_sel;
  logic signed [31:0] dq_sel;
  logic signed [31:0] att_sel;
  logic [63:0]        nsum_d;
  logic [31:0]        vm_d;
  logic [31:0]        nm_d;
  logic               hneg_d;
  logic signed [63:0] hacc_d;
  logic [63:0]        amag_d;
  logic [33:0]        rnd_d;
  logic [31:0]        rcl_d;
  logic               out_load;
  logic               qneg_d;

  assign th_sel  = theta_q[idx_q];
  assign qw_sel  = qw_q[idx_q];
  assign dq_sel  = dq_q[idx_q];
  assign att_sel = att_q[k_q ^ idx_q];

  assign issue = !wait_q;

  always_comb begin
    mul_a = mag32(th_sel);
    mul_b = mag32(th_sel);
    case (state_q)
      S_VEC: begin
        mul_a = mag32(s_q);
        mul_b = mag32(th_sel);
      end
      S_NSQ: begin
        mul_a = mag32(qw_sel);
        mul_b = mag32(qw_sel);
      end
      S_HAM: begin
        mul_a = mag32(dq_sel);
        mul_b = mag32(att_sel);
      end
      default: ;
    endcase
  end

  assign mul_start  = issue && (state_q == S_TSQ || state_q == S_VEC ||
                                state_q == S_NSQ || state_q == S_HAM);
  assign div_start  = issue && (state_q == S_VDIV || state_q == S_NDIV);
  assign sqrt_start = issue && (state_q == S_ASQ || state_q == S_NRT);
  assign cor_start  = issue && (state_q == S_SIN);

  assign div_n = (state_q == S_VDIV) ? mul_p
               : ({3'd0, mag32(qw_sel), 29'd0} + {33'd0, r_q[31:1]});
  assign div_d = (state_q == S_VDIV) ? a_q : r_q;
  assign cor_ang = $signed({3'd0, a_q, 1'b0});

  always_comb begin
    case (state_q)
      S_TSQ, S_VEC, S_NSQ, S_HAM: op_done = mul_done;
      S_VDIV, S_NDIV:             op_done = div_done;
      S_ASQ, S_NRT:               op_done = sqrt_done;
      S_SIN:                      op_done = cor_done;
      default:                    op_done = 1'b0;
    endcase
  end

  assign nsum_d = sum_q + {2'b00, mul_p[63:2]};
  assign vm_d   = div_q[31:0];
  assign nm_d   = (div_q > {32'd0, SAT_Q30}) ? SAT_Q30 : div_q[31:0];
  assign hneg_d = dq_sel[31] ^ att_sel[31] ^ ham_neg(k_q, idx_q);
  assign hacc_d = hneg_d ? acc_q - $signed(mul_p) : acc_q + $signed(mul_p);
  // round half away from zero to Q2.30 and clamp
  assign amag_d = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
  assign rnd_d  = 34'((amag_d + 64'd536870912) >> 30);
  assign rcl_d  = (rnd_d > CLAMP32) ? CLAMP32[31:0] : rnd_d[31:0];
  assign qneg_d = qw_q[0][31];

  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wait_q      <= 1'b0;
      pass_q      <= 1'b0;
      idx_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      att_q[0]    <= ONE_Q30;
      att_q[1]    <= '0;
      att_q[2]    <= '0;
      att_q[3]    <= '0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;

      if (issue && (mul_start || div_start || sqrt_start || cor_start)) wait_q <= 1'b1;
      else if (op_done) wait_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            pass_q  <= 1'b0;
            idx_q   <= '0;
            state_q <= S_TSQ;
          end
        end
        S_TSQ: begin
          if (op_done) begin
            idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
            if (idx_q == 2'd2) state_q <= S_ASQ;
          end
        end
        S_ASQ: begin
          if (op_done) begin
            idx_q   <= '0;
            state_q <= (sqrt_root < SMALL_ANGLE) ? S_NSQ : S_SIN;
          end
        end
        S_SIN: if (op_done) state_q <= S_VEC;
        S_VEC: if (op_done) state_q <= S_VDIV;
        S_VDIV: begin
          if (op_done) begin
            idx_q   <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
            state_q <= (idx_q == 2'd2) ? S_NSQ : S_VEC;
          end
        end
        S_NSQ: begin
          if (op_done) begin
            idx_q <= idx_q + 2'd1;
            if (idx_q == 2'd3) state_q <= (nsum_d < NORM_EPS) ? S_NFIX : S_NRT;
          end
        end
        S_NRT: if (op_done) state_q <= S_NDIV;
        S_NDIV: begin
          if (op_done) begin
            idx_q <= idx_q + 2'd1;
            if (idx_q == 2'd3) state_q <= S_NFIX;
          end
        end
        S_NFIX: begin
          idx_q <= '0;
          k_q   <= '0;
          if (!pass_q) begin
            pass_q  <= 1'b1;
            state_q <= S_HAM;
          end else begin
            for (int i = 0; i < 4; i++) att_q[i] <= qneg_d ? -qw_q[i] : qw_q[i];
            state_q <= S_DONE;
          end
        end
        S_HAM: begin
          if (op_done) begin
            idx_q <= idx_q + 2'd1;
            if (idx_q == 2'd3) state_q <= S_HRND;
          end
        end
        S_HRND: begin
          k_q     <= k_q + 2'd1;
          state_q <= (k_q == 2'd3) ? S_NSQ : S_HAM;
        end
        S_DONE: if (out_load) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          theta_q[0] <= in_data_i.theta_x;
          theta_q[1] <= in_data_i.theta_y;
          theta_q[2] <= in_data_i.theta_z;
          sum_q      <= '0;
          flag_q     <= 1'b0;
        end
      end
      S_TSQ: if (op_done) sum_q <= sum_q + mul_p;
      S_ASQ: begin
        if (op_done) begin
          a_q   <= sqrt_root;
          sum_q <= '0;
          // first-order form below the small-angle threshold
          qw_q[0] <= ONE_Q30;
          qw_q[1] <= {theta_q[0][30:0], 1'b0};
          qw_q[2] <= {theta_q[1][30:0], 1'b0};
          qw_q[3] <= {theta_q[2][30:0], 1'b0};
        end
      end
      S_SIN: begin
        if (op_done) begin
          qw_q[0] <= cor_cos;
          s_q     <= cor_sin;
        end
      end
      S_VDIV: begin
        if (op_done) begin
          qw_q[2'(idx_q + 2'd1)] <= (s_q[31] ^ th_sel[31]) ? -$signed(vm_d) : $signed(vm_d);
        end
      end
      S_NSQ: begin
        if (op_done) begin
          sum_q <= nsum_d;
          if (idx_q == 2'd3 && nsum_d < NORM_EPS) begin
            qw_q[0] <= ONE_Q30;
            qw_q[1] <= '0;
            qw_q[2] <= '0;
            qw_q[3] <= '0;
            flag_q  <= 1'b1;
          end
        end
      end
      S_NRT: if (op_done) r_q <= sqrt_root;
      S_NDIV: begin
        if (op_done) qw_q[idx_q] <= qw_sel[31] ? -$signed(nm_d) : $signed(nm_d);
      end
      S_NFIX: begin
        acc_q <= '0;
        if (!pass_q) begin
          for (int i = 0; i < 4; i++) dq_q[i] <= qneg_d ? -qw_q[i] : qw_q[i];
        end
      end
      S_HAM: if (op_done) acc_q <= hacc_d;
      S_HRND: begin
        qw_q[k_q] <= acc_q[63] ? -$signed(rcl_d) : $signed(rcl_d);
        acc_q     <= '0;
        sum_q     <= '0;
      end
      default: ;
    endcase

    if (out_load) begin
      out_data_q.att_w      <= att_q[0][30:0];
      out_data_q.att_x      <= att_q[1];
      out_data_q.att_y      <= att_q[2];
      out_data_q.att_z      <= att_q[3];
      out_data_q.norm_reset <= flag_q;
    end
  end

  qap_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  qap_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  qap_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sum_q),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  qap_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .ang_i   (cor_ang),
    .done_o  (cor_done),
    .sin_o   (cor_sin),
    .cos_o   (cor_cos)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

FILE: rtl/qap_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module qap_mul import qap_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [63:0] prod_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [31:0] a_q;
  logic [31:0] hi_q;
  logic [31:0] lo_q;
  logic [32:0] sum_d;

  // one multiplier bit per cycle, partial sum shifts down into lo
  assign sum_d = {1'b0, hi_q} + {1'b0, (lo_q[0] ? a_q : 32'd0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= sum_d[32:1];
      lo_q <= {sum_d[0], lo_q[31:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

`default_nettype wire

FILE: rtl/qap_div.sv
`timescale 1ns / 1ps
`default_nettype none

module qap_div import qap_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quot_o
);

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [31:0] dvs_q;
  logic [31:0] rem_q;
  logic [63:0] quo_q;
  logic [32:0] shl_d;
  logic [33:0] diff_d;

  // restoring division: dividend bits leave at the top, quotient bits enter at the bottom
  assign shl_d  = {rem_q, quo_q[63]};
  assign diff_d = {1'b0, shl_d} - {2'b00, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      if (!diff_d[33]) begin
        rem_q <= diff_d[31:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= shl_d[31:0];
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

FILE: rtl/qap_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module qap_sqrt import qap_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [63:0] rad_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [35:0] shl_d;
  logic [35:0] trial_d;
  logic [36:0] diff_d;

  // two radicand bits per cycle, one root bit per cycle
  assign shl_d   = {rem_q, rad_q[63:62]};
  assign trial_d = {2'b00, root_q, 2'b01};
  assign diff_d  = {1'b0, shl_d} - {1'b0, trial_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[61:0], 2'b00};
      if (!diff_d[36]) begin
        rem_q  <= diff_d[33:0];
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        rem_q  <= shl_d[33:0];
        root_q <= {root_q[30:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

FILE: rtl/qap_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

module qap_cordic import qap_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [35:0] ang_i,
  output logic               done_o,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_WRAP = 2'd1;
  localparam logic [1:0] C_FOLD = 2'd2;
  localparam logic [1:0] C_ROT  = 2'd3;
  localparam logic [4:0] LAST_ITER = 5'(CORDIC_ITERS - 1);

  logic [1:0]         state_q;
  logic               done_q;
  logic [4:0]         cnt_q;
  logic               neg_q;
  logic signed [35:0] h_q;
  logic signed [35:0] x_q;
  logic signed [35:0] y_q;
  logic signed [35:0] z_q;
  logic signed [35:0] dx_d;
  logic signed [35:0] dy_d;
  logic signed [35:0] at_d;
  logic signed [35:0] s_d;
  logic signed [35:0] c_d;

  assign dx_d = y_q >>> cnt_q;
  assign dy_d = x_q >>> cnt_q;
  assign at_d = $signed({6'd0, atan_q30(cnt_q)});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        C_IDLE: if (start_i) state_q <= C_WRAP;
        C_WRAP: state_q <= C_FOLD;
        C_FOLD: begin
          cnt_q   <= '0;
          state_q <= C_ROT;
        end
        C_ROT: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == LAST_ITER) begin
            done_q  <= 1'b1;
            state_q <= C_IDLE;
          end
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      C_IDLE: if (start_i) h_q <= ang_i;
      C_WRAP: if (h_q > PI_Q30) h_q <= h_q - TWO_PI_Q30;
      C_FOLD: begin
        // fold into [-pi/2, pi/2]; a step of pi flips both outputs
        x_q <= CORDIC_K;
        y_q <= '0;
        if (h_q > HALF_PI_Q30) begin
          z_q   <= h_q - PI_Q30;
          neg_q <= 1'b1;
        end else if (h_q < -HALF_PI_Q30) begin
          z_q   <= h_q + PI_Q30;
          neg_q <= 1'b1;
        end else begin
          z_q   <= h_q;
          neg_q <= 1'b0;
        end
      end
      C_ROT: begin
        if (!z_q[35]) begin
          x_q <= x_q - dx_d;
          y_q <= y_q + dy_d;
          z_q <= z_q - at_d;
        end else begin
          x_q <= x_q + dx_d;
          y_q <= y_q - dy_d;
          z_q <= z_q + at_d;
        end
      end
      default: ;
    endcase
  end

  assign s_d    = neg_q ? -y_q : y_q;
  assign c_d    = neg_q ? -x_q : x_q;
  assign sin_o  = s_d[31:0];
  assign cos_o  = c_d[31:0];
  assign done_o = done_q;

endmodule

`default_nettype wire
